// File: rtl/core/pma_pkg.sv
// shared constants, types and sigmoid table for the prototype mask assembly block
`timescale 1ns / 1ps

package pma_pkg;

   localparam int MAX_COEFFICIENTS_DEFAULT = 32;
   localparam int VALUE_WIDTH_DEFAULT      = 16;

   localparam int CHANNEL_WIDTH   = 5;
   localparam int COUNT_WIDTH     = 6;
   localparam int PROB_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   // wide enough for channel and count compares at any depth up to 64
   localparam int INDEX_EXT_WIDTH = 7;

   // running sum wraps like a 64-bit signed integer
   localparam int SUM_WIDTH = 64;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET     = 6'd32;
   localparam logic [PROB_WIDTH-1:0]  THRESHOLD_RESET = 8'd127;

   typedef enum logic [0:0] {
      ACTION_LOAD  = 1'b0,
      ACTION_PROTO = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEFFICIENT_COUNT = 1'b0,
      CSR_MASK_THRESHOLD    = 1'b1
   } csr_index_type;

   // round(255*sigmoid(x)) at the midpoints x = (k+0.5)/16, k = 0..127
   localparam logic [PROB_WIDTH-1:0] SIGMOID_UPPER [128] = '{
      8'd129, 8'd133, 8'd137, 8'd141, 8'd145, 8'd149, 8'd153, 8'd157,
      8'd161, 8'd164, 8'd168, 8'd171, 8'd175, 8'd178, 8'd182, 8'd185,
      8'd188, 8'd191, 8'd194, 8'd197, 8'd200, 8'd202, 8'd205, 8'd207,
      8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220, 8'd222, 8'd224,
      8'd225, 8'd227, 8'd229, 8'd230, 8'd231, 8'd233, 8'd234, 8'd235,
      8'd236, 8'd237, 8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243,
      8'd243, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247,
      8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd250, 8'd250, 8'd250,
      8'd251, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd252,
      8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253,
      8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

endpackage

// File: rtl/core/pma_if.sv
// request and result channel interfaces for the prototype mask assembly block
`timescale 1ns / 1ps

interface pma_req_if #(
   parameter int VALUE_WIDTH = pma_pkg::VALUE_WIDTH_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic [0:0]                          action;
   logic [pma_pkg::CHANNEL_WIDTH-1:0]   channel;
   logic signed [VALUE_WIDTH-1:0]       value;

   modport source (output valid, output action, output channel, output value, input ready);
   modport sink   (input valid, input action, input channel, input value, output ready);
endinterface

interface pma_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pma_pkg::PROB_WIDTH-1:0]    probability;
   logic                              mask_bit;

   modport source (output valid, output probability, output mask_bit, input ready);
   modport sink   (input valid, input probability, input mask_bit, output ready);
endinterface

// File: rtl/core/prototype_mask_assembly_top.sv
// top level of the prototype mask assembly block
`timescale 1ns / 1ps

// Takes one request per clock: a load request writes one mask coefficient, a prototype request
// multiplies one channel value by its coefficient and adds it to the running sum (channel 0
// restarts it). A prototype request on the last channel in use produces one result: the rounded
// sigmoid probability and the thresholded mask bit. Throughput is one request per cycle, set by
// the single registered multiplier and the registered accumulate; the pipeline (coefficient
// read, multiply, accumulate, table lookup) only holds while a finished result waits on the
// output. Prototype requests on channels at or above the coefficient count produce nothing.
// The user must write configuration only while no request is in flight; unchecked by the block.
module prototype_mask_assembly_top #(
   parameter int MAX_COEFFICIENTS = pma_pkg::MAX_COEFFICIENTS_DEFAULT,
   parameter int VALUE_WIDTH      = pma_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pma_req_if.sink                               req_bus,
   pma_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [pma_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pma_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int ADDR_WIDTH    = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1;
   localparam int PRODUCT_WIDTH = 2 * VALUE_WIDTH;
   localparam int EXT           = pma_pkg::INDEX_EXT_WIDTH;
   localparam logic [EXT-1:0] MAX_EXT = EXT'(MAX_COEFFICIENTS);

   // configuration
   logic [pma_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [pma_pkg::PROB_WIDTH-1:0]  threshold_ff;

   // pipeline control
   logic                            enable;
   logic                            accept;
   logic                            is_load;
   logic [EXT-1:0]                  channel_ext;
   logic [EXT-1:0]                  count_eff;
   logic                            load_write;
   logic                            proto_use;

   // stage a: coefficient read
   logic                            a_valid_ff;
   logic                            a_restart_ff;
   logic                            a_last_ff;
   logic signed [VALUE_WIDTH-1:0]   a_value_ff;
   logic signed [VALUE_WIDTH-1:0]   a_coef;

   // stage b: product
   logic                            b_valid_ff;
   logic                            b_restart_ff;
   logic                            b_last_ff;
   logic signed [PRODUCT_WIDTH-1:0] b_product_ff;
   logic signed [PRODUCT_WIDTH-1:0] b_product_in;

   // stage c: running sum
   logic                            c_valid_ff;
   logic signed [pma_pkg::SUM_WIDTH-1:0] sum_ff;
   logic signed [pma_pkg::SUM_WIDTH-1:0] sum_in;
   logic signed [pma_pkg::SUM_WIDTH-1:0] product_ext;

   // stage d: result register
   logic                            rsp_valid_ff;
   logic [pma_pkg::PROB_WIDTH-1:0]  prob_ff;
   logic                            mask_ff;
   logic [pma_pkg::PROB_WIDTH-1:0]  prob_in;
   logic                            mask_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= pma_pkg::COUNT_RESET;
         threshold_ff <= pma_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pma_pkg::CSR_COEFFICIENT_COUNT: count_ff <= csr_write_data[pma_pkg::COUNT_WIDTH-1:0];
            pma_pkg::CSR_MASK_THRESHOLD:    threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign enable        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = enable;
   assign accept        = req_bus.valid && enable;
   assign is_load       = (req_bus.action == pma_pkg::ACTION_LOAD);
   assign channel_ext   = EXT'(req_bus.channel);

   always_comb begin
      if (count_ff == '0) begin
         count_eff = EXT'(1);
      end else if (EXT'(count_ff) > MAX_EXT) begin
         count_eff = MAX_EXT;
      end else begin
         count_eff = EXT'(count_ff);
      end
      load_write = accept && is_load && (channel_ext < MAX_EXT);
      proto_use  = accept && !is_load && (channel_ext < count_eff);
   end

   pma_coef_store #(
      .DEPTH       (MAX_COEFFICIENTS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_coef_store (
      .clock        (clock),
      .write_enable (load_write),
      .read_enable  (proto_use),
      .address      (channel_ext[ADDR_WIDTH-1:0]),
      .write_data   (req_bus.value),
      .read_data    (a_coef)
   );

   assign b_product_in = a_coef * a_value_ff;
   assign product_ext  = {{(pma_pkg::SUM_WIDTH - PRODUCT_WIDTH){b_product_ff[PRODUCT_WIDTH-1]}},
                          b_product_ff};
   assign sum_in       = b_restart_ff ? product_ext : (sum_ff + product_ext);

   pma_sigmoid #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_sigmoid (
      .sum         (sum_ff),
      .threshold   (threshold_ff),
      .probability (prob_in),
      .mask_bit    (mask_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else if (enable) begin
         a_valid_ff   <= proto_use;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff && b_last_ff;
         rsp_valid_ff <= c_valid_ff;
         if (b_valid_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_restart_ff <= (channel_ext == '0);
         a_last_ff    <= (channel_ext == (count_eff - EXT'(1)));
         a_value_ff   <= req_bus.value;
         b_restart_ff <= a_restart_ff;
         b_last_ff    <= a_last_ff;
         b_product_ff <= b_product_in;
         if (c_valid_ff) begin
            prob_ff <= prob_in;
            mask_ff <= mask_in;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.probability = prob_ff;
   assign rsp_bus.mask_bit    = mask_ff;

   // a new result only comes from a finished sum
   result_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(c_valid_ff))
      else $error("result raised without a finished sum");

   // the running sum holds while a result is stalled
   sum_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(sum_ff))
      else $error("running sum moved during output stall");

   // the last channel always marks its sum as finished
   last_channel_finishes: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_last_ff && enable) |=> c_valid_ff)
      else $error("last channel did not finish the sum");

endmodule

// File: rtl/core/pma_coef_store.sv
// single-port coefficient memory with registered read
`timescale 1ns / 1ps

module pma_coef_store #(
   parameter int DEPTH       = pma_pkg::MAX_COEFFICIENTS_DEFAULT,
   parameter int VALUE_WIDTH = pma_pkg::VALUE_WIDTH_DEFAULT,
   parameter int ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          write_enable,
   input  logic                          read_enable,
   input  logic [ADDR_WIDTH-1:0]         address,
   input  logic signed [VALUE_WIDTH-1:0] write_data,
   output logic signed [VALUE_WIDTH-1:0] read_data
);

   logic signed [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/core/pma_sigmoid.sv
// clamps the running sum, looks up the sigmoid table and applies the mask threshold
`timescale 1ns / 1ps

module pma_sigmoid #(
   parameter int VALUE_WIDTH = pma_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic signed [pma_pkg::SUM_WIDTH-1:0] sum,
   input  logic [pma_pkg::PROB_WIDTH-1:0]       threshold,
   output logic [pma_pkg::PROB_WIDTH-1:0]       probability,
   output logic                                 mask_bit
);

   // sum carries 2*(VALUE_WIDTH-4) fraction bits, table steps are 1/16
   localparam int SHIFT = 2 * VALUE_WIDTH - 12;

   logic signed [pma_pkg::SUM_WIDTH-1:0] scaled;
   logic [pma_pkg::PROB_WIDTH-1:0]       index;
   logic [pma_pkg::PROB_WIDTH-2:0]       half_index;
   logic [pma_pkg::PROB_WIDTH-1:0]       entry;

   always_comb begin
      scaled = sum >>> SHIFT;
      if (scaled > $signed(pma_pkg::SUM_WIDTH'(127))) begin
         index = 8'd255;
      end else if (scaled < -$signed(pma_pkg::SUM_WIDTH'(128))) begin
         index = 8'd0;
      end else begin
         index = {~scaled[7], scaled[6:0]};
      end

      // lower half mirrors the upper half
      half_index  = index[7] ? index[6:0] : ~index[6:0];
      entry       = pma_pkg::SIGMOID_UPPER[half_index];
      probability = index[7] ? entry : (8'd255 - entry);
      mask_bit    = (probability > threshold);
   end

endmodule
